// ----- hdl/numeric_literal_parser_macros.svh -----
// Assertion macros for the numeric literal parser.
`ifndef NUMERIC_LITERAL_PARSER_MACROS_SVH
`define NUMERIC_LITERAL_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define NLP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define NLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/nlp_pkg.sv -----
// Package: widths, character codes, result kinds and digit decode for the literal parser.
package nlp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_UC_B  = 8'h42;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_DEC  = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;
  localparam logic [1:0] KIND_BIN  = 2'd3;

  localparam logic [1:0] IDX_FIRST  = 2'd0;
  localparam logic [1:0] IDX_SECOND = 2'd1;
  localparam logic [1:0] IDX_BODY   = 2'd2;

  typedef struct packed {
    logic       ok;
    logic [3:0] digit;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      r.ok = 1'b1;
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      d = c - CH_LC_A + HEX_LETTER_BASE;
      r.ok = 1'b1;
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      d = c - CH_UC_A + HEX_LETTER_BASE;
      r.ok = 1'b1;
    end
    r.digit = d[3:0];
    return r;
  endfunction

endpackage

// ----- hdl/numeric_literal_parser.sv -----
// Numeric literal parser: classifies a token as decimal, hex or binary and returns its value.
//
// Characters of a token arrive one per transfer, the last one flagged by last_char. A new
// character is taken every cycle unless a result waits in the output register while its
// receiver stalls; the input then stalls until that result is taken. The result (value and
// kind) appears in the output register in the cycle after the transfer of the last character.
// One character per cycle is set by the single update of the three running accumulators and
// their match flags. Kind 0 means no match and then value is 0; 1 decimal (optional sign),
// 2 hex (0x/0X prefix), 3 binary (0b/0B prefix). Values wrap modulo 2^VALUE_WIDTH.
`include "numeric_literal_parser_macros.svh"

module numeric_literal_parser
  import nlp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  char_code,
  input  logic                        last_char,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_WIDTH-1:0] value,
  output logic [1:0]                  kind
);

  logic [1:0]             char_index, char_index_next;
  logic                   negative_sign, negative_sign_next;
  logic                   dec_still_ok, dec_still_ok_next;
  logic                   hex_still_ok, hex_still_ok_next;
  logic                   bin_still_ok, bin_still_ok_next;
  logic [VALUE_WIDTH-1:0] dec_accum, dec_accum_next;
  logic [VALUE_WIDTH-1:0] hex_accum, hex_accum_next;
  logic [VALUE_WIDTH-1:0] bin_accum, bin_accum_next;

  logic                          accept;
  logic                          is_dec;
  logic [3:0]                    dec_digit;
  hex_digit_t                    hex_dig;
  logic                          prefix_ok;
  logic signed [VALUE_WIDTH-1:0] result_sel;
  logic [1:0]                    kind_sel;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    is_dec    = (char_code >= CH_0) && (char_code <= CH_9);
    dec_digit = char_code[3:0];
    hex_dig   = hex_decode(char_code);

    negative_sign_next = negative_sign;
    dec_still_ok_next  = dec_still_ok;
    hex_still_ok_next  = hex_still_ok;
    bin_still_ok_next  = bin_still_ok;
    dec_accum_next     = dec_accum;
    hex_accum_next     = hex_accum;
    bin_accum_next     = bin_accum;

    priority if (char_index == IDX_FIRST &&
                 (char_code == CH_PLUS || char_code == CH_MINUS)) begin
      negative_sign_next = (char_code == CH_MINUS);
    end else if (is_dec) begin
      dec_accum_next = (dec_accum << 3) + (dec_accum << 1) +
                       VALUE_WIDTH'(dec_digit);
    end else begin
      dec_still_ok_next = 1'b0;
    end

    priority if (char_index == IDX_FIRST) begin
      if (char_code != CH_0) begin
        hex_still_ok_next = 1'b0;
        bin_still_ok_next = 1'b0;
      end
    end else if (char_index == IDX_SECOND) begin
      if (char_code != CH_LC_X && char_code != CH_UC_X) hex_still_ok_next = 1'b0;
      if (char_code != CH_LC_B && char_code != CH_UC_B) bin_still_ok_next = 1'b0;
    end else begin
      if (hex_dig.ok) hex_accum_next = (hex_accum << 4) + VALUE_WIDTH'(hex_dig.digit);
      else            hex_still_ok_next = 1'b0;
      if (char_code == CH_0 || char_code == CH_1) begin
        bin_accum_next = (bin_accum << 1) + VALUE_WIDTH'(char_code[0]);
      end else begin
        bin_still_ok_next = 1'b0;
      end
    end

    char_index_next = (char_index == IDX_BODY) ? IDX_BODY : char_index + 2'd1;

    prefix_ok = (char_index == IDX_BODY);
    priority if (dec_still_ok_next) begin
      kind_sel   = KIND_DEC;
      result_sel = negative_sign_next ? -dec_accum_next : dec_accum_next;
    end else if (hex_still_ok_next && prefix_ok) begin
      kind_sel   = KIND_HEX;
      result_sel = hex_accum_next;
    end else if (bin_still_ok_next && prefix_ok) begin
      kind_sel   = KIND_BIN;
      result_sel = bin_accum_next;
    end else begin
      kind_sel   = KIND_NONE;
      result_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_char)) begin
      char_index    <= IDX_FIRST;
      negative_sign <= 1'b0;
      dec_still_ok  <= 1'b1;
      hex_still_ok  <= 1'b1;
      bin_still_ok  <= 1'b1;
      dec_accum     <= '0;
      hex_accum     <= '0;
      bin_accum     <= '0;
    end else if (accept) begin
      char_index    <= char_index_next;
      negative_sign <= negative_sign_next;
      dec_still_ok  <= dec_still_ok_next;
      hex_still_ok  <= hex_still_ok_next;
      bin_still_ok  <= bin_still_ok_next;
      dec_accum     <= dec_accum_next;
      hex_accum     <= hex_accum_next;
      bin_accum     <= bin_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_char) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_char) begin
      value <= OUT_WIDTH'(result_sel);
      kind  <= kind_sel;
    end
  end

  `NLP_ASSERT_SAME(a_stall_only_when_full, in_stall, out_valid, "input stalled with empty output")
  `NLP_ASSERT_NEXT(a_last_gives_result, accept && last_char, out_valid, "result missing after last")
  `NLP_ASSERT_NEXT(a_last_restarts, accept && last_char, char_index == IDX_FIRST, "no restart")
  `NLP_ASSERT_SAME(a_none_is_zero, out_valid && kind == KIND_NONE, value == '0, "value not zero")

endmodule

// ----- sim/tb.sv -----
// Testbench for the numeric literal parser: directed and random tokens checked by a predictor.
`timescale 1ns / 100ps

module tb;
  import nlp_pkg::*;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] value;
    logic [1:0]                  kind;
  } literal_result_t;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [7:0]                  char_code;
  logic                        last_char;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [OUT_WIDTH-1:0] value;
  logic [1:0]                  kind;

  literal_result_t literal_results[$];
  int mismatch_count = 0;
  int hold_len = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  logic [1:0]             char_pos;
  logic                   neg_sign;
  logic                   dec_ok;
  logic                   hex_ok;
  logic                   bin_ok;
  logic [VALUE_WIDTH-1:0] dec_acc;
  logic [VALUE_WIDTH-1:0] hex_acc;
  logic [VALUE_WIDTH-1:0] bin_acc;

  numeric_literal_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .kind      (kind)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void clear_parser();
    char_pos = IDX_FIRST;
    neg_sign = 1'b0;
    dec_ok   = 1'b1;
    hex_ok   = 1'b1;
    bin_ok   = 1'b1;
    dec_acc  = '0;
    hex_acc  = '0;
    bin_acc  = '0;
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic is_last);
    logic [1:0]             pos;
    int                     hv;
    logic [VALUE_WIDTH-1:0] v;
    literal_result_t        r;
    pos = char_pos;

    if (pos == IDX_FIRST && (c == "+" || c == "-")) begin
      neg_sign = (c == "-");
    end else if (c >= "0" && c <= "9") begin
      dec_acc = dec_acc * 10 + (c - "0");
    end else begin
      dec_ok = 1'b0;
    end

    if (c >= "0" && c <= "9") begin
      hv = c - "0";
    end else if (c >= "a" && c <= "f") begin
      hv = c - "a" + 10;
    end else if (c >= "A" && c <= "F") begin
      hv = c - "A" + 10;
    end else begin
      hv = 16;
    end

    if (pos == IDX_FIRST) begin
      if (c != "0") begin
        hex_ok = 1'b0;
        bin_ok = 1'b0;
      end
    end else if (pos == IDX_SECOND) begin
      if (c != "x" && c != "X") hex_ok = 1'b0;
      if (c != "b" && c != "B") bin_ok = 1'b0;
    end else begin
      if (hv < 16) hex_acc = (hex_acc << 4) + hv;
      else hex_ok = 1'b0;
      if (c == "0" || c == "1") bin_acc = (bin_acc << 1) + (c - "0");
      else bin_ok = 1'b0;
    end

    if (pos != IDX_BODY) char_pos = pos + 2'd1;
    if (!is_last) return;

    // a prefix needs at least one digit after it
    if (pos != IDX_BODY) begin
      hex_ok = 1'b0;
      bin_ok = 1'b0;
    end

    if (dec_ok) begin
      r.kind = KIND_DEC;
      v = neg_sign ? -dec_acc : dec_acc;
    end else if (hex_ok) begin
      r.kind = KIND_HEX;
      v = hex_acc;
    end else if (bin_ok) begin
      r.kind = KIND_BIN;
      v = bin_acc;
    end else begin
      r.kind = KIND_NONE;
      v = '0;
    end
    r.value = OUT_WIDTH'($signed(v));
    literal_results = {literal_results, r};
    clear_parser();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last_char <= is_last;
    do @(posedge clk); while (in_stall);
    parse_char(c, is_last);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (literal_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic string rand_text(input string alphabet, input int n);
    string r;
    int    i;
    int    k;
    r = "";
    for (i = 0; i < n; i++) begin
      k = $urandom_range(0, alphabet.len() - 1);
      r = {r, alphabet.substr(k, k)};
    end
    return r;
  endfunction

  // receiver: stall a random count per result, or a long hold when asked
  initial begin
    int n;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end else begin
        n = rx_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_results
    literal_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (literal_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d kind %0d", value, kind));
      end else begin
        want = literal_results.pop_front();
        if (value !== want.value)
          report_mismatch($sformatf("value got %0d want %0d", value, want.value));
        if (kind !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
      end
    end
  end

  task automatic test_directed_tokens();
    string tokens[] = '{"0", "7", "+", "-", "-0", "+42", "-1", "2147483647", "-2147483648",
                        "4294967296", "0x", "0X", "0b", "0B", "0x1F", "0XaBcDeF09",
                        "0x100000000", "0b1011", "0B0",
                        "0b11111111111111111111111111111111", "0b12", "0xg", "--5", "1-2"};
    foreach (tokens[i]) send_text(tokens[i]);
    send_char(8'h00, 1'b1);
    send_char(8'h80, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char("0", 1'b0);
    send_char(8'hF8, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_tokens();
    string s;
    string pfx;
    string signs[3] = '{"", "+", "-"};
    int    sent;
    int    pick;
    int    n;
    int    i;
    sent = 0;
    while (sent < 500) begin
      tx_idle_on = ((sent / 150) % 3) != 0;
      rx_idle_on = ((sent / 100) % 4) != 1;
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: begin
          s = {signs[$urandom_range(0, 2)], rand_text("0123456789", $urandom_range(0, 12))};
          if (s.len() == 0) s = "5";
        end
        3, 4: begin
          pfx = $urandom_range(0, 1) ? "0x" : "0X";
          s = {pfx, rand_text("0123456789abcdefABCDEF", $urandom_range(0, 10))};
        end
        5, 6: begin
          pfx = $urandom_range(0, 1) ? "0b" : "0B";
          s = {pfx, rand_text("01", $urandom_range(0, 36))};
        end
        7, 8: begin
          pfx = rand_text("xXbB", 1);
          s = {"0", pfx, rand_text("0123456789abcdefABCDEF", $urandom_range(1, 6))};
          s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(1, 255));
        end
        default: begin
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)), i == n - 1);
          s = "";
          sent += n;
        end
      endcase
      if (s.len() != 0) begin
        send_text(s);
        sent += s.len();
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_output_hold();
    int i;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_len = 300;
    for (i = 0; i < 60; i++) send_text(rand_text("0123456789", 1 + i % 3));
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    int i;
    int j;
    for (i = 0; i < 8; i++) begin
      for (j = 0; j < 3; j++) send_text({"-", rand_text("0123456789", $urandom_range(1, 10))});
      wait_drained();
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    char_code <= '0;
    last_char <= 1'b0;
    clear_parser();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_tokens();
    test_random_tokens();
    test_output_hold();
    test_sender_pause();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
